// ===== rtl/core/corexy_step_command_generator_macros.svh =====
// Assertion macros used by the back end RTL of the step command generator.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef COREXY_STEP_COMMAND_GENERATOR_MACROS_SVH
`define COREXY_STEP_COMMAND_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/csg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoreXY step command generator package
// Shared types and constants of the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package csg_pkg;

    localparam int POS_W   = 24;
    localparam int PULSE_W = 24;
    localparam int MAG_W   = 24;
    localparam int SCALE_W = 16;
    localparam int SPEED_W = 16;
    localparam int STEP_W  = 24;
    localparam int BL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACKLASH   = 3'd5;

    localparam logic [SPEED_W-1:0] MIN_SPEED = 16'd10;
    localparam logic [STEP_W-1:0]  STEP_MAX  = 24'hFFFFFF;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'd0,
        DIR_POS     = 2'd1,
        DIR_NEG     = 2'd2
    } csg_dir_t;

    typedef struct packed {
        logic                       mode;
        logic signed [PULSE_W-1:0]  ta;
        logic signed [PULSE_W-1:0]  tb;
        logic signed [PULSE_W-1:0]  tz;
    } csg_item_t;

    typedef struct packed {
        logic [2:0]          invert;
        logic [SPEED_W-1:0]  base_speed;
        logic [BL_W-1:0]     backlash;
    } csg_move_cfg_t;

    typedef struct packed {
        logic                skipped;
        logic                a_go;
        logic                a_cw;
        logic [SPEED_W-1:0]  a_speed;
        logic [STEP_W-1:0]   a_steps;
        logic                b_go;
        logic                b_cw;
        logic [SPEED_W-1:0]  b_speed;
        logic [STEP_W-1:0]   b_steps;
        logic                z_go;
        logic                z_cw;
        logic [STEP_W-1:0]   z_steps;
    } csg_result_t;

endpackage

// ===== rtl/core/corexy_step_command_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoreXY step command generator
// Turns target positions into per-motor step commands with backlash handling.
// ----------------------------------------------------------------------------
// Targets enter through push/full and each produces exactly one transaction
// on the result side, read through empty/pop in arrival order. A result is
// present while empty is low and leaves on a cycle with pop high.
// Configuration must be written by the user through cfg_we/cfg_index/cfg_data
// only while no transaction is in flight; the block does not enforce this.
// Unused indexes are ignored. The front end handles one item at a time:
// the accept cycle, three multiply and round passes of one shared multiplier
// and the hand-off to the queue, and it holds full high after an accepted
// push until that hand-off. The back end skips the divider for a set-position
// or skipped move and runs the 16-step serial divider of the speed ratio for
// a real move; it takes no new item from the queue until its result is
// written out, so the back end limits sustained throughput for moves.
// A queue of QUEUE_DEPTH items and the output register let the front end
// keep accepting while pop is held low, until both are filled.
// Reset clears the stored pulse counts and direction memory and loads the
// default configuration.
// ----------------------------------------------------------------------------
module corexy_step_command_generator
    import csg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic                      mode,
    input  logic signed [POS_W-1:0]   target_x,
    input  logic signed [POS_W-1:0]   target_y,
    input  logic signed [POS_W-1:0]   target_z,
    output logic                      empty,
    input  logic                      pop,
    output logic                      skipped,
    output logic                      a_go,
    output logic                      a_cw,
    output logic [SPEED_W-1:0]        a_speed,
    output logic [STEP_W-1:0]         a_steps,
    output logic                      b_go,
    output logic                      b_cw,
    output logic [SPEED_W-1:0]        b_speed,
    output logic [STEP_W-1:0]         b_steps,
    output logic                      z_go,
    output logic                      z_cw,
    output logic [STEP_W-1:0]         z_steps
);

    logic [SCALE_W-1:0]  steps_x_reg, steps_y_reg, steps_z_reg;
    logic [2:0]          invert_reg;
    logic [SPEED_W-1:0]  base_speed_reg;
    logic [BL_W-1:0]     backlash_reg;

    logic           q_push, q_full, q_pop, q_empty;
    csg_item_t      q_wr_data, q_rd_data;
    csg_move_cfg_t  move_cfg;
    csg_result_t    result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_x_reg    <= 16'd20480;
            steps_y_reg    <= 16'd20480;
            steps_z_reg    <= 16'd25600;
            invert_reg     <= 3'd0;
            base_speed_reg <= 16'd60;
            backlash_reg   <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEPS_X:    steps_x_reg    <= cfg_data;
                REG_STEPS_Y:    steps_y_reg    <= cfg_data;
                REG_STEPS_Z:    steps_z_reg    <= cfg_data;
                REG_INVERT:     invert_reg     <= cfg_data[2:0];
                REG_BASE_SPEED: base_speed_reg <= cfg_data;
                REG_BACKLASH:   backlash_reg   <= cfg_data[BL_W-1:0];
                default:        ;
            endcase
        end
    end

    assign move_cfg.invert     = invert_reg;
    assign move_cfg.base_speed = base_speed_reg;
    assign move_cfg.backlash   = backlash_reg;

    csg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .mode     (mode),
        .target_x (target_x),
        .target_y (target_y),
        .target_z (target_z),
        .steps_x  (steps_x_reg),
        .steps_y  (steps_y_reg),
        .steps_z  (steps_z_reg),
        .q_push   (q_push),
        .q_data   (q_wr_data),
        .q_full   (q_full)
    );

    csg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    csg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .cfg     (move_cfg),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    assign skipped = result.skipped;
    assign a_go    = result.a_go;
    assign a_cw    = result.a_cw;
    assign a_speed = result.a_speed;
    assign a_steps = result.a_steps;
    assign b_go    = result.b_go;
    assign b_cw    = result.b_cw;
    assign b_speed = result.b_speed;
    assign b_steps = result.b_steps;
    assign z_go    = result.z_go;
    assign z_cw    = result.z_cw;
    assign z_steps = result.z_steps;

endmodule

// ===== rtl/core/csg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts targets, applies the CoreXY mapping and converts each axis to
// rounded pulse counts with one shared multiplier.
// ----------------------------------------------------------------------------
module csg_front
    import csg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      mode,
    input  logic signed [POS_W-1:0]   target_x,
    input  logic signed [POS_W-1:0]   target_y,
    input  logic signed [POS_W-1:0]   target_z,
    input  logic [SCALE_W-1:0]        steps_x,
    input  logic [SCALE_W-1:0]        steps_y,
    input  logic [SCALE_W-1:0]        steps_z,
    output logic                      q_push,
    output csg_item_t                 q_data,
    input  logic                      q_full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_RND  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    typedef enum logic [1:0] {
        AXIS_A = 2'd0,
        AXIS_B = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    front_state_t state_reg, state_next;
    axis_t        axis_reg, axis_next;

    logic                       mode_reg;
    logic signed [POS_W:0]      pos_a_reg;
    logic signed [POS_W:0]      pos_b_reg;
    logic signed [POS_W-1:0]    pos_z_reg;
    logic signed [POS_W+17:0]   product_reg;
    logic signed [PULSE_W-1:0]  ta_reg, tb_reg, tz_reg;

    logic signed [POS_W:0]      pos_sel;
    logic [SCALE_W-1:0]         scale_sel;
    logic [POS_W+17:0]          prod_mag;
    logic [POS_W+17:0]          prod_rnd;
    logic [PULSE_W-1:0]         q_mag;
    logic signed [PULSE_W-1:0]  pulse;

    always_comb
    begin
        case (axis_reg)
            AXIS_A:
            begin
                pos_sel   = pos_a_reg;
                scale_sel = steps_x;
            end
            AXIS_B:
            begin
                pos_sel   = pos_b_reg;
                scale_sel = steps_y;
            end
            default:
            begin
                pos_sel   = {pos_z_reg[POS_W-1], pos_z_reg};
                scale_sel = steps_z;
            end
        endcase
    end

    assign prod_mag = product_reg[POS_W+17] ? 42'(-product_reg) : 42'(product_reg);
    assign prod_rnd = prod_mag + 42'(1 << 17);
    assign q_mag    = {1'b0, prod_rnd[40:18]};
    assign pulse    = product_reg[POS_W+17] ? -$signed(q_mag) : $signed(q_mag);

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    axis_next  = AXIS_A;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_RND;
            end
            F_RND:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    axis_next  = axis_t'(axis_reg + 2'd1);
                    state_next = F_MUL;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            axis_reg  <= AXIS_A;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            mode_reg  <= mode;
            pos_a_reg <= {target_y[POS_W-1], target_y} - {target_x[POS_W-1], target_x};
            pos_b_reg <= {target_y[POS_W-1], target_y} + {target_x[POS_W-1], target_x};
            pos_z_reg <= target_z;
        end
        if (state_reg == F_MUL)
        begin
            product_reg <= pos_sel * $signed({1'b0, scale_sel});
        end
        if (state_reg == F_RND)
        begin
            case (axis_reg)
                AXIS_A:  ta_reg <= pulse;
                AXIS_B:  tb_reg <= pulse;
                default: tz_reg <= pulse;
            endcase
        end
    end

    assign full        = (state_reg != F_IDLE);
    assign q_push      = (state_reg == F_PUSH) && !q_full;
    assign q_data.mode = mode_reg;
    assign q_data.ta   = ta_reg;
    assign q_data.tb   = tb_reg;
    assign q_data.tz   = tz_reg;

endmodule

// ===== rtl/core/csg_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module csg_fifo
    import csg_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  csg_item_t  wr_data,
    output logic       full,
    input  logic       rd_en,
    output csg_item_t  rd_data,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csg_item_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr, do_rd;

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

endmodule

// ===== rtl/core/csg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Forms deltas against the stored pulse counts, divides the speed ratio
// serially for real moves and builds one result per item: a move command, or a skipped or set-position result.
// ----------------------------------------------------------------------------
module csg_back
    import csg_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  csg_item_t      q_data,
    output logic           q_pop,
    input  csg_move_cfg_t  cfg,
    output logic           empty,
    input  logic           pop,
    output csg_result_t    result
);

`include "corexy_step_command_generator_macros.svh"

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_DELTA = 5'b00010,
        B_SETUP = 5'b00100,
        B_DIV   = 5'b01000,
        B_DONE  = 5'b10000
    } back_state_t;

    localparam int NUM_W = SPEED_W + MAG_W;

    back_state_t state_reg, state_next;

    csg_item_t                  item_reg;
    logic signed [PULSE_W-1:0]  abs_a_reg, abs_b_reg, abs_z_reg;
    csg_dir_t                   last_a_reg, last_b_reg;
    logic [MAG_W-1:0]           mag_a_reg, mag_b_reg, mag_z_reg;
    logic                       neg_a_reg, neg_b_reg, neg_z_reg;
    logic [NUM_W-1:0]           rem_reg;
    logic [NUM_W-1:0]           dvs_reg;
    logic [SPEED_W-1:0]         quo_reg;
    logic [3:0]                 cnt_reg;
    logic                       out_valid_reg;
    csg_result_t                out_reg;

    logic signed [PULSE_W:0]    da, db, dz;
    logic                       a_big;
    logic [MAG_W-1:0]           big, small_mag;
    logic                       small_move;
    logic                       write_out;
    csg_result_t                res;
    logic                       rev_a, rev_b;
    logic [STEP_W:0]            sum_a, sum_b;
    csg_dir_t                   dir_a, dir_b;

    function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s);
        clamp_speed = (s < MIN_SPEED) ? MIN_SPEED : s;
    endfunction

    function automatic logic [STEP_W-1:0] sat_steps(input logic [STEP_W:0] s);
        sat_steps = s[STEP_W] ? STEP_MAX : s[STEP_W-1:0];
    endfunction

    assign da = {item_reg.ta[PULSE_W-1], item_reg.ta} - {abs_a_reg[PULSE_W-1], abs_a_reg};
    assign db = {item_reg.tb[PULSE_W-1], item_reg.tb} - {abs_b_reg[PULSE_W-1], abs_b_reg};
    assign dz = {item_reg.tz[PULSE_W-1], item_reg.tz} - {abs_z_reg[PULSE_W-1], abs_z_reg};

    assign a_big      = (mag_a_reg >= mag_b_reg);
    assign big        = a_big ? mag_a_reg : mag_b_reg;
    assign small_mag  = a_big ? mag_b_reg : mag_a_reg;
    assign small_move = (mag_a_reg[MAG_W-1:1] == '0) && (mag_b_reg[MAG_W-1:1] == '0)
                        && (mag_z_reg[MAG_W-1:1] == '0);

    assign dir_a = neg_a_reg ? DIR_NEG : DIR_POS;
    assign dir_b = neg_b_reg ? DIR_NEG : DIR_POS;
    assign rev_a = (last_a_reg != DIR_UNKNOWN) && (last_a_reg != dir_a);
    assign rev_b = (last_b_reg != DIR_UNKNOWN) && (last_b_reg != dir_b);
    assign sum_a = {1'b0, mag_a_reg} + (rev_a ? (STEP_W+1)'(cfg.backlash) : '0);
    assign sum_b = {1'b0, mag_b_reg} + (rev_b ? (STEP_W+1)'(cfg.backlash) : '0);

    always_comb
    begin
        res = '0;
        if (!item_reg.mode)
        begin
            if (small_move)
            begin
                res.skipped = 1'b1;
            end
            else
            begin
                if (mag_a_reg != '0)
                begin
                    res.a_go    = 1'b1;
                    res.a_cw    = !neg_a_reg ^ cfg.invert[0];
                    res.a_speed = clamp_speed(a_big ? cfg.base_speed : quo_reg);
                    res.a_steps = sat_steps(sum_a);
                end
                if (mag_b_reg != '0)
                begin
                    res.b_go    = 1'b1;
                    res.b_cw    = !neg_b_reg ^ cfg.invert[1];
                    res.b_speed = clamp_speed(a_big ? quo_reg : cfg.base_speed);
                    res.b_steps = sat_steps(sum_b);
                end
                if (mag_z_reg != '0)
                begin
                    res.z_go    = 1'b1;
                    res.z_cw    = !neg_z_reg ^ cfg.invert[2];
                    res.z_steps = mag_z_reg;
                end
            end
        end
    end

    assign write_out = (state_reg == B_DONE) && (!out_valid_reg || pop);
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_DELTA;
                end
            end
            B_DELTA:
            begin
                state_next = B_SETUP;
            end
            B_SETUP:
            begin
                state_next = (item_reg.mode || small_move) ? B_DONE : B_DIV;
            end
            B_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (write_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            abs_a_reg     <= '0;
            abs_b_reg     <= '0;
            abs_z_reg     <= '0;
            last_a_reg    <= DIR_UNKNOWN;
            last_b_reg    <= DIR_UNKNOWN;
        end
        else
        begin
            state_reg <= state_next;
            if (write_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (write_out && (item_reg.mode || !small_move))
            begin
                abs_a_reg <= item_reg.ta;
                abs_b_reg <= item_reg.tb;
                abs_z_reg <= item_reg.tz;
                if (item_reg.mode)
                begin
                    last_a_reg <= DIR_UNKNOWN;
                    last_b_reg <= DIR_UNKNOWN;
                end
                else
                begin
                    if (mag_a_reg != '0)
                    begin
                        last_a_reg <= dir_a;
                    end
                    if (mag_b_reg != '0)
                    begin
                        last_b_reg <= dir_b;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_data;
        end
        if (state_reg == B_DELTA)
        begin
            neg_a_reg <= da[PULSE_W];
            neg_b_reg <= db[PULSE_W];
            neg_z_reg <= dz[PULSE_W];
            mag_a_reg <= da[PULSE_W] ? MAG_W'(-da) : MAG_W'(da);
            mag_b_reg <= db[PULSE_W] ? MAG_W'(-db) : MAG_W'(db);
            mag_z_reg <= dz[PULSE_W] ? MAG_W'(-dz) : MAG_W'(dz);
        end
        if (state_reg == B_SETUP)
        begin
            rem_reg <= NUM_W'(cfg.base_speed * small_mag);
            dvs_reg <= {1'b0, big, 15'd0};
            quo_reg <= '0;
            cnt_reg <= 4'd15;
        end
        if (state_reg == B_DIV)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_reg <= rem_reg - dvs_reg;
                quo_reg <= {quo_reg[SPEED_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[SPEED_W-2:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (write_out)
        begin
            out_reg <= res;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    `CSG_ASSERT_NEXT(a_div_ends, (state_reg == B_DIV) && (cnt_reg == '0),
        state_reg == B_DONE, "divider did not finish after sixteen steps")
    `CSG_ASSERT_SAME(a_skip_clean, out_valid_reg && out_reg.skipped,
        !out_reg.a_go && !out_reg.b_go && !out_reg.z_go, "skipped move carries a motor command")
    `CSG_ASSERT_SAME(a_min_speed, out_valid_reg && out_reg.a_go,
        out_reg.a_speed >= MIN_SPEED, "motor A speed below minimum")
    `CSG_ASSERT_NEXT(a_dir_known, write_out && res.a_go,
        last_a_reg != DIR_UNKNOWN, "motor A direction not recorded after move")

endmodule

// ===== verif/corexy_step_command_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoreXY step command generator testbench
// Drives target positions and register settings into the block, predicts
// every move command from its own model of the kinematics, rounding, skip
// rule and backlash handling, and compares each result field by field.
// ----------------------------------------------------------------------------
module corexy_step_command_generator_tb;
    import csg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic MODE_MOVE = 1'b0;
    localparam logic MODE_SET  = 1'b1;

    class move_scoreboard;
        longint unsigned steps_x, steps_y, steps_z, base_speed, backlash;
        logic [2:0] invert;
        longint pos_a, pos_b, pos_c;
        csg_dir_t dir_a, dir_b;
        csg_result_t expected_moves[$];
        int errors;

        function new();
            steps_x = 20480;
            steps_y = 20480;
            steps_z = 25600;
            invert = 3'd0;
            base_speed = 60;
            backlash = 10;
            pos_a = 0;
            pos_b = 0;
            pos_c = 0;
            dir_a = DIR_UNKNOWN;
            dir_b = DIR_UNKNOWN;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STEPS_X:    steps_x = 64'(data);
                REG_STEPS_Y:    steps_y = 64'(data);
                REG_STEPS_Z:    steps_z = 64'(data);
                REG_INVERT:     invert = data[2:0];
                REG_BASE_SPEED: base_speed = 64'(data);
                REG_BACKLASH:   backlash = 64'(data[7:0]);
                default: ;
            endcase
        endfunction

        function longint round_pulses(longint pos, longint unsigned scale);
            longint p;
            longint q;
            p = pos * longint'(scale);
            q = ((p < 0 ? -p : p) + 131072) >>> 18;
            return (p < 0) ? -q : q;
        endfunction

        function logic [SPEED_W-1:0] axis_speed(longint a, longint m);
            longint s;
            if (m == 0)
                return '0;
            s = (longint'(base_speed) * a) / m;
            if (a > 0 && s < longint'(MIN_SPEED))
                s = longint'(MIN_SPEED);
            return s[SPEED_W-1:0];
        endfunction

        function logic [STEP_W-1:0] sat(longint v);
            return (v > longint'(STEP_MAX)) ? STEP_MAX : v[STEP_W-1:0];
        endfunction

        function logic [STEP_W-1:0] backlash_steps(longint d, ref csg_dir_t last);
            longint s;
            csg_dir_t dir;
            s = (d < 0) ? -d : d;
            dir = (d > 0) ? DIR_POS : DIR_NEG;
            if (last != DIR_UNKNOWN && last != dir)
                s += longint'(backlash);
            last = dir;
            return sat(s);
        endfunction

        function void note_input(logic m, logic signed [POS_W-1:0] x,
                                 logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
            longint ta, tb, tz, da, db, dz, aa, ab, az, mx;
            csg_result_t r;
            r = '0;
            ta = round_pulses(longint'(y) - longint'(x), steps_x);
            tb = round_pulses(longint'(y) + longint'(x), steps_y);
            tz = round_pulses(longint'(z), steps_z);
            if (m == MODE_SET)
            begin
                pos_a = ta;
                pos_b = tb;
                pos_c = tz;
                dir_a = DIR_UNKNOWN;
                dir_b = DIR_UNKNOWN;
                expected_moves.push_back(r);
                return;
            end
            da = ta - pos_a;
            db = tb - pos_b;
            dz = tz - pos_c;
            aa = (da < 0) ? -da : da;
            ab = (db < 0) ? -db : db;
            az = (dz < 0) ? -dz : dz;
            if (aa < 2 && ab < 2 && az < 2)
            begin
                r.skipped = 1'b1;
                expected_moves.push_back(r);
                return;
            end
            mx = (aa > ab) ? aa : ab;
            if (aa != 0)
            begin
                r.a_go = 1'b1;
                r.a_cw = (da >= 0) ^ invert[0];
                r.a_speed = axis_speed(aa, mx);
                r.a_steps = backlash_steps(da, dir_a);
            end
            if (ab != 0)
            begin
                r.b_go = 1'b1;
                r.b_cw = (db >= 0) ^ invert[1];
                r.b_speed = axis_speed(ab, mx);
                r.b_steps = backlash_steps(db, dir_b);
            end
            if (az != 0)
            begin
                r.z_go = 1'b1;
                r.z_cw = (dz >= 0) ^ invert[2];
                r.z_steps = sat(az);
            end
            pos_a = ta;
            pos_b = tb;
            pos_c = tz;
            expected_moves.push_back(r);
        endfunction

        function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(csg_result_t act);
            csg_result_t e;
            if (expected_moves.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, act);
                return;
            end
            e = expected_moves.pop_front();
            cmp("skipped", 64'(e.skipped), 64'(act.skipped));
            cmp("a_go", 64'(e.a_go), 64'(act.a_go));
            cmp("a_cw", 64'(e.a_cw), 64'(act.a_cw));
            cmp("a_speed", 64'(e.a_speed), 64'(act.a_speed));
            cmp("a_steps", 64'(e.a_steps), 64'(act.a_steps));
            cmp("b_go", 64'(e.b_go), 64'(act.b_go));
            cmp("b_cw", 64'(e.b_cw), 64'(act.b_cw));
            cmp("b_speed", 64'(e.b_speed), 64'(act.b_speed));
            cmp("b_steps", 64'(e.b_steps), 64'(act.b_steps));
            cmp("z_go", 64'(e.z_go), 64'(act.z_go));
            cmp("z_cw", 64'(e.z_cw), 64'(act.z_cw));
            cmp("z_steps", 64'(e.z_steps), 64'(act.z_steps));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic push;
    logic full;
    logic mode;
    logic signed [POS_W-1:0] target_x, target_y, target_z;
    logic empty;
    logic pop;
    logic skipped, a_go, a_cw, b_go, b_cw, z_go, z_cw;
    logic [SPEED_W-1:0] a_speed, b_speed;
    logic [STEP_W-1:0] a_steps, b_steps, z_steps;

    move_scoreboard sb;
    int idle_cycles;
    int moves_sent;
    int results_seen;
    logic signed [POS_W-1:0] last_x, last_y, last_z;

    corexy_step_command_generator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full), .mode(mode),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .empty(empty), .pop(pop),
        .skipped(skipped),
        .a_go(a_go), .a_cw(a_cw), .a_speed(a_speed), .a_steps(a_steps),
        .b_go(b_go), .b_cw(b_cw), .b_speed(b_speed), .b_steps(b_steps),
        .z_go(z_go), .z_cw(z_cw), .z_steps(z_steps)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : result_side
        int gap;
        csg_result_t act;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            act = {skipped, a_go, a_cw, a_speed, a_steps, b_go, b_cw, b_speed, b_steps,
                   z_go, z_cw, z_steps};
            sb.check_result(act);
            results_seen++;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic send_target(logic m, logic signed [POS_W-1:0] x,
                               logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                               bit use_gap);
        int gap;
        gap = use_gap ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        mode <= m;
        target_x <= x;
        target_y <= y;
        target_z <= z;
        do @(posedge clk); while (full);
        sb.note_input(m, x, y, z);
        last_x = x;
        last_y = y;
        last_z = z;
        moves_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.expected_moves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                              logic [2:0] inv, logic [15:0] spd, logic [7:0] bl);
        drain();
        write_reg(REG_STEPS_X, sx);
        write_reg(REG_STEPS_Y, sy);
        write_reg(REG_STEPS_Z, sz);
        write_reg(REG_INVERT, {13'd0, inv});
        write_reg(REG_BASE_SPEED, spd);
        write_reg(REG_BACKLASH, {8'd0, bl});
        write_reg(REG_UNUSED, 16'($urandom()));
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int kind;
        logic signed [POS_W-1:0] x, y, z;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 19);
            x = POS_W'($urandom());
            y = POS_W'($urandom());
            z = POS_W'($urandom());
            if (kind < 9)
            begin
                x = POS_W'(last_x + $signed(POS_W'($urandom_range(0, 8000))) - 4000);
                y = POS_W'(last_y + $signed(POS_W'($urandom_range(0, 8000))) - 4000);
                z = POS_W'(last_z + $signed(POS_W'($urandom_range(0, 8000))) - 4000);
            end
            else if (kind < 13)
            begin
                x = POS_W'(last_x + $signed(POS_W'($urandom_range(0, 6))) - 3);
                y = POS_W'(last_y + $signed(POS_W'($urandom_range(0, 6))) - 3);
                z = POS_W'(last_z + $signed(POS_W'($urandom_range(0, 6))) - 3);
            end
            if (i == count / 2)
                drain();
            send_target((kind == 19) ? MODE_SET : MODE_MOVE, x, y, z, i % 200 < 170);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        pop = 1'b0;
        mode = 1'b0;
        target_x = '0;
        target_y = '0;
        target_z = '0;
        idle_cycles = 0;
        moves_sent = 0;
        results_seen = 0;
        last_x = '0;
        last_y = '0;
        last_z = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first move after reset has no backlash, then reversals,
        // tiny moves that are skipped, field extremes and set-position.
        send_target(MODE_MOVE, 24'sd1024, 24'sd0, 24'sd0, 1'b1);
        send_target(MODE_MOVE, -24'sd1024, 24'sd0, 24'sd512, 1'b1);
        send_target(MODE_MOVE, -24'sd1024, 24'sd2048, 24'sd512, 1'b1);
        send_target(MODE_MOVE, -24'sd1024, 24'sd2049, 24'sd513, 1'b1);
        send_target(MODE_MOVE, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        send_target(MODE_MOVE, 24'sh800000, 24'sh800000, 24'sh800000, 1'b1);
        send_target(MODE_MOVE, 24'sh7FFFFF, 24'sh800000, 24'sh000000, 1'b1);
        send_target(MODE_MOVE, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        send_target(MODE_SET, 24'sd100, 24'sd200, 24'sd300, 1'b1);
        send_target(MODE_MOVE, 24'sd100, 24'sd200, 24'sd300, 1'b1);
        send_target(MODE_MOVE, 24'sd0, 24'sd0, 24'sd0, 1'b1);
        send_target(MODE_MOVE, 24'sd5000, 24'sd5000, 24'sd0, 1'b1);
        send_target(MODE_MOVE, 24'sd0, 24'sd0, -24'sd4000, 1'b1);
        send_target(MODE_SET, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b1);
        send_target(MODE_MOVE, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0);
        random_phase(300);

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 8'hFF);
        send_target(MODE_MOVE, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b1);
        send_target(MODE_MOVE, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b1);
        random_phase(300);

        set_config(16'd0, 16'd0, 16'd0, 3'd0, 16'd0, 8'd0);
        random_phase(60);

        set_config(16'd20480, 16'd300, 16'd1, 3'd5, 16'd5, 8'd1);
        send_target(MODE_MOVE, 24'sd100000, 24'sd3000, 24'sd0, 1'b1);
        random_phase(300);

        for (int p = 0; p < 3; p++)
        begin
            set_config(16'($urandom()), 16'($urandom_range(1, 65535)), 16'($urandom()),
                       3'($urandom_range(0, 7)), 16'($urandom()), 8'($urandom()));
            random_phase(330);
        end

        drain();
        $display("Covered %0d input and %0d result transactions over seven register settings,",
                 moves_sent, results_seen);
        $display("including set-position, skipped moves, reversals and extreme settings.");
        if (sb.errors == 0 && sb.expected_moves.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/csg_pkg.sv
rtl/core/csg_front.sv
rtl/core/csg_fifo.sv
rtl/core/csg_back.sv
rtl/core/corexy_step_command_generator.sv
verif/corexy_step_command_generator_tb.sv
